// ----- rtl/bwe_pkg.sv -----
// Shared types, codes and constants of the byte-pair word encoder.
package bwe_pkg;

  localparam int ID_W           = 16;
  localparam int SLOT_W         = 12;
  localparam int BYTE_W         = 8;
  localparam int CNT_W          = 13;
  localparam int DEF_MAX_RULES  = 4096;
  localparam int DEF_MAX_WORD   = 32;
  localparam int DEF_TOKEN_BITS = 16;
  localparam int Q_DEPTH        = 4;

  localparam logic [BYTE_W-1:0] SEP_LIMIT = 8'd32;

  localparam logic FUNC_RULE = 1'b0;
  localparam logic FUNC_BYTE = 1'b1;

  localparam logic CFG_BOS   = 1'b0;
  localparam logic CFG_RULES = 1'b1;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] rule_slot;
    logic [ID_W-1:0]   pair_left;
    logic [ID_W-1:0]   pair_right;
    logic [ID_W-1:0]   merged_token;
    logic [BYTE_W-1:0] text_byte;
    logic              text_last;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] token_id;
    logic            has_token;
    logic            text_end;
    logic            word_cut;
  } out_item_t;

  typedef struct packed {
    logic              is_byte;
    logic              bos;
    logic              sep;
    logic              last;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   left;
    logic [ID_W-1:0]   right;
    logic [ID_W-1:0]   merged;
    logic [BYTE_W-1:0] text_byte;
  } cmd_t;

endpackage

// ----- rtl/bwe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bwe_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bwe_fifo.sv -----
// Small register FIFO used for the command queue and the result queue.
module bwe_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : PW'(wp_r + 1'b1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : PW'(rp_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ----- rtl/bwe_front.sv -----
// Front end: accepts input items, tracks text state and classifies them into commands.
module bwe_front #(
  parameter int MAX_RULES = bwe_pkg::DEF_MAX_RULES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  bwe_pkg::in_item_t in_item,
  output logic              in_full,
  output logic              cmd_push,
  output bwe_pkg::cmd_t     cmd,
  input  logic              cmd_full
);
  import bwe_pkg::*;

  logic inside_r, inside_nxt;
  logic accept;

  assign accept   = in_push & ~cmd_full;
  assign in_full  = cmd_full;
  assign cmd_push = in_push;

  always_comb begin
    cmd.is_byte   = (in_item.func == FUNC_BYTE);
    cmd.bos       = ~inside_r;
    cmd.sep       = (in_item.text_byte <= SEP_LIMIT);
    cmd.last      = in_item.text_last;
    cmd.slot_ok   = (32'(in_item.rule_slot) < 32'(MAX_RULES));
    cmd.slot      = in_item.rule_slot;
    cmd.left      = in_item.pair_left;
    cmd.right     = in_item.pair_right;
    cmd.merged    = in_item.merged_token;
    cmd.text_byte = in_item.text_byte;
  end

  always_comb begin
    inside_nxt = inside_r;
    if (accept && in_item.func == FUNC_BYTE) begin
      inside_nxt = ~in_item.text_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
    end else begin
      inside_r <= inside_nxt;
    end
  end

endmodule

// ----- rtl/bwe_back.sv -----
// Back end: rule table, word buffers, merge passes and result emission.
module bwe_back #(
  parameter int MAX_RULES  = bwe_pkg::DEF_MAX_RULES,
  parameter int MAX_WORD   = bwe_pkg::DEF_MAX_WORD,
  parameter int TOKEN_BITS = bwe_pkg::DEF_TOKEN_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  bwe_pkg::cmd_t             cmd,
  input  logic                      cmd_empty,
  output logic                      cmd_pop,
  input  logic [bwe_pkg::ID_W-1:0]  bos_token,
  input  logic [bwe_pkg::CNT_W-1:0] rule_count,
  input  logic                      out_full,
  output logic                      out_push,
  output bwe_pkg::out_item_t        out_item
);
  import bwe_pkg::*;

  localparam int RA_W  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int RC_W  = $clog2(MAX_RULES + 1);
  localparam int WA_W  = $clog2(MAX_WORD);
  localparam int LEN_W = $clog2(MAX_WORD + 1);
  localparam logic [ID_W-1:0] IDM =
    (TOKEN_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((32'd1 << TOKEN_BITS) - 32'd1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_BOS     = 3'd1;
  localparam logic [2:0] S_BODY    = 3'd2;
  localparam logic [2:0] S_RFETCH  = 3'd3;
  localparam logic [2:0] S_PASS    = 3'd4;
  localparam logic [2:0] S_EMIT_RD = 3'd5;
  localparam logic [2:0] S_EMIT_WR = 3'd6;
  localparam logic [2:0] S_MARK    = 3'd7;

  logic [2:0]       state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             cut_r, cut_nxt;
  logic             cur_r, cur_nxt;
  logic [RC_W-1:0]  r_r, r_nxt;
  logic [LEN_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [LEN_W-1:0] j_r, j_nxt;
  logic [ID_W-1:0]  hold_r, hold_nxt;
  logic             hold_vld_r, hold_vld_nxt;

  logic [RC_W-1:0]   n_rules;
  logic              rule_we;
  logic [3*ID_W-1:0] rule_q;
  logic [ID_W-1:0]   rule_a, rule_b, rule_m;
  logic [1:0]        wb_we;
  logic [WA_W-1:0]   wb_waddr, wb_raddr;
  logic [ID_W-1:0]   wb_wdata, wb_q0, wb_q1, cur_q;
  logic [LEN_W-1:0]  body_len;
  logic              start_close;

  assign n_rules = (32'(rule_count) > 32'(MAX_RULES)) ? RC_W'(MAX_RULES) : RC_W'(rule_count);
  assign rule_a  = rule_q[3*ID_W-1:2*ID_W];
  assign rule_b  = rule_q[2*ID_W-1:ID_W];
  assign rule_m  = rule_q[ID_W-1:0];
  assign cur_q   = cur_r ? wb_q1 : wb_q0;

  bwe_ram #(.W(3*ID_W), .DEPTH(MAX_RULES)) u_rule_ram (
    .clk   (clk),
    .we    (rule_we),
    .waddr (RA_W'(cmd.slot)),
    .wdata ({cmd.left & IDM, cmd.right & IDM, cmd.merged & IDM}),
    .raddr (r_r[RA_W-1:0]),
    .rdata (rule_q)
  );

  bwe_ram #(.W(ID_W), .DEPTH(MAX_WORD)) u_word_ram0 (
    .clk   (clk),
    .we    (wb_we[0]),
    .waddr (wb_waddr),
    .wdata (wb_wdata),
    .raddr (wb_raddr),
    .rdata (wb_q0)
  );

  bwe_ram #(.W(ID_W), .DEPTH(MAX_WORD)) u_word_ram1 (
    .clk   (clk),
    .we    (wb_we[1]),
    .waddr (wb_waddr),
    .wdata (wb_wdata),
    .raddr (wb_raddr),
    .rdata (wb_q1)
  );

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    cut_nxt      = cut_r;
    cur_nxt      = cur_r;
    r_nxt        = r_r;
    rd_idx_nxt   = rd_idx_r;
    rd_vld_nxt   = 1'b0;
    j_nxt        = j_r;
    hold_nxt     = hold_r;
    hold_vld_nxt = hold_vld_r;
    cmd_pop      = 1'b0;
    rule_we      = 1'b0;
    out_push     = 1'b0;
    out_item     = '0;
    wb_we        = 2'b00;
    wb_waddr     = j_r[WA_W-1:0];
    wb_wdata     = hold_r;
    wb_raddr     = rd_idx_r[WA_W-1:0];
    body_len     = len_r;
    start_close  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (!cmd.is_byte) begin
            rule_we = cmd.slot_ok;
          end else begin
            cmd_nxt   = cmd;
            state_nxt = cmd.bos ? S_BOS : S_BODY;
          end
        end
      end
      S_BOS: begin
        if (!out_full) begin
          out_push           = 1'b1;
          out_item.token_id  = bos_token & IDM;
          out_item.has_token = 1'b1;
          out_item.text_end  = cmd_r.last & cmd_r.sep;
          len_nxt            = '0;
          cut_nxt            = 1'b0;
          state_nxt          = S_BODY;
        end
      end
      S_BODY: begin
        state_nxt = S_IDLE;
        if (!cmd_r.sep) begin
          if (len_r < LEN_W'(MAX_WORD)) begin
            wb_we[cur_r] = 1'b1;
            wb_waddr     = len_r[WA_W-1:0];
            wb_wdata     = ID_W'(cmd_r.text_byte) & IDM;
            body_len     = LEN_W'(len_r + 1'b1);
          end else begin
            cut_nxt = 1'b1;
          end
          len_nxt     = body_len;
          start_close = cmd_r.last;
        end else if (len_r != '0) begin
          start_close = 1'b1;
        end else if (cmd_r.last && !cmd_r.bos) begin
          state_nxt = S_MARK;
        end
        if (start_close) begin
          r_nxt        = '0;
          rd_idx_nxt   = '0;
          j_nxt        = '0;
          hold_vld_nxt = 1'b0;
          state_nxt    = (n_rules == '0) ? S_EMIT_RD : S_RFETCH;
        end
      end
      S_RFETCH: begin
        state_nxt = S_PASS;
      end
      S_PASS: begin
        if (rd_idx_r < len_r) begin
          rd_idx_nxt = LEN_W'(rd_idx_r + 1'b1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          if (hold_vld_r && hold_r == rule_a && cur_q == rule_b) begin
            wb_we[~cur_r] = 1'b1;
            wb_wdata      = rule_m;
            j_nxt         = LEN_W'(j_r + 1'b1);
            hold_vld_nxt  = 1'b0;
          end else if (hold_vld_r) begin
            wb_we[~cur_r] = 1'b1;
            j_nxt         = LEN_W'(j_r + 1'b1);
            hold_nxt      = cur_q;
          end else begin
            hold_nxt     = cur_q;
            hold_vld_nxt = 1'b1;
          end
        end else if (rd_idx_r == len_r) begin
          wb_we[~cur_r] = hold_vld_r;
          len_nxt       = LEN_W'(j_r + LEN_W'(hold_vld_r));
          cur_nxt       = ~cur_r;
          r_nxt         = RC_W'(r_r + 1'b1);
          rd_idx_nxt    = '0;
          j_nxt         = '0;
          hold_vld_nxt  = 1'b0;
          state_nxt     = (RC_W'(r_r + 1'b1) == n_rules) ? S_EMIT_RD : S_RFETCH;
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (!out_full) begin
          out_push           = 1'b1;
          out_item.token_id  = cur_q;
          out_item.has_token = 1'b1;
          out_item.text_end  = cmd_r.last & (LEN_W'(rd_idx_r + 1'b1) == len_r);
          out_item.word_cut  = cut_r;
          if (LEN_W'(rd_idx_r + 1'b1) == len_r) begin
            len_nxt    = '0;
            cut_nxt    = 1'b0;
            rd_idx_nxt = '0;
            state_nxt  = S_IDLE;
          end else begin
            rd_idx_nxt = LEN_W'(rd_idx_r + 1'b1);
            state_nxt  = S_EMIT_RD;
          end
        end
      end
      S_MARK: begin
        if (!out_full) begin
          out_push          = 1'b1;
          out_item.text_end = 1'b1;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      len_r      <= '0;
      cut_r      <= 1'b0;
      cur_r      <= 1'b0;
      r_r        <= '0;
      rd_idx_r   <= '0;
      rd_vld_r   <= 1'b0;
      j_r        <= '0;
      hold_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      cut_r      <= cut_nxt;
      cur_r      <= cur_nxt;
      r_r        <= r_nxt;
      rd_idx_r   <= rd_idx_nxt;
      rd_vld_r   <= rd_vld_nxt;
      j_r        <= j_nxt;
      hold_vld_r <= hold_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    hold_r <= hold_nxt;
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_push |-> !out_full) else $error("result transfer into a full queue");

  a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty) else $error("command taken from an empty queue");

  a_pass_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PASS) |-> (j_r <= rd_idx_r)) else $error("merge writer ahead of reader");

  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_RD || state_r == S_EMIT_WR) |-> (rd_idx_r < len_r))
    else $error("emit index beyond word length");

  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_WORD)) else $error("word length above buffer capacity");

endmodule

// ----- rtl/bpe_word_encoder.sv -----
// Byte-pair word encoder: top level with configuration registers and queues.
// Rule load: the back end writes the rule table; a text byte is classified in the front end and stored
// by the back end. Word close: one merge pass per rule in use, one word-buffer read per cycle, then each
// emitted token goes through the registered buffer read port (a read state, then a write state).
// Throughput: one input transfer per cycle into a 4-deep command queue, held off while it is full.
// Reset: synchronous active-low rst_n clears control state; rule table and word buffers
// hold undefined data until written, with no clearing pass.
module bpe_word_encoder #(
  parameter int MAX_RULES  = bwe_pkg::DEF_MAX_RULES,
  parameter int MAX_WORD   = bwe_pkg::DEF_MAX_WORD,
  parameter int TOKEN_BITS = bwe_pkg::DEF_TOKEN_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  bwe_pkg::in_item_t        in_data,
  output logic                     empty,
  input  logic                     pop,
  output bwe_pkg::out_item_t       out_data,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [bwe_pkg::ID_W-1:0] cfg_data
);
  import bwe_pkg::*;

  logic [ID_W-1:0]  bos_token_r, bos_token_nxt;
  logic [CNT_W-1:0] rule_count_r, rule_count_nxt;

  cmd_t      f_cmd, b_cmd;
  logic      f_push, cmd_full, cmd_empty, cmd_pop;
  logic      res_push, res_full;
  out_item_t res_item;

  always_comb begin
    bos_token_nxt  = bos_token_r;
    rule_count_nxt = rule_count_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BOS:   bos_token_nxt  = cfg_data;
        CFG_RULES: rule_count_nxt = cfg_data[CNT_W-1:0];
        default:   bos_token_nxt  = bos_token_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bos_token_r  <= ID_W'(256);
      rule_count_r <= '0;
    end else begin
      bos_token_r  <= bos_token_nxt;
      rule_count_r <= rule_count_nxt;
    end
  end

  bwe_front #(.MAX_RULES(MAX_RULES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (push),
    .in_item  (in_data),
    .in_full  (full),
    .cmd_push (f_push),
    .cmd      (f_cmd),
    .cmd_full (cmd_full)
  );

  bwe_fifo #(.W($bits(cmd_t)), .DEPTH(Q_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (f_cmd),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (b_cmd),
    .empty (cmd_empty)
  );

  bwe_back #(
    .MAX_RULES  (MAX_RULES),
    .MAX_WORD   (MAX_WORD),
    .TOKEN_BITS (TOKEN_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (b_cmd),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .bos_token  (bos_token_r),
    .rule_count (rule_count_r),
    .out_full   (res_full),
    .out_push   (res_push),
    .out_item   (res_item)
  );

  bwe_fifo #(.W($bits(out_item_t)), .DEPTH(Q_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_item),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

endmodule

// ----- tb/sv/tb_bpe_word_encoder.sv -----
// Self-checking testbench of the byte-pair word encoder with a scoreboard class.
`timescale 1ns / 1ps

import bwe_pkg::*;

class token_scoreboard;
  logic [ID_W-1:0] pair_l [4096];
  logic [ID_W-1:0] pair_r [4096];
  logic [ID_W-1:0] pair_m [4096];
  logic [ID_W-1:0] word_ids [32];
  int unsigned     n_ids;
  bit              in_text;
  bit              cut;
  logic [ID_W-1:0] bos_id;
  logic [12:0]     rule_cnt;
  out_item_t       tokens_due [$];
  int              errors;

  function new();
    n_ids    = 0;
    in_text  = 0;
    cut      = 0;
    bos_id   = 16'd256;
    rule_cnt = 13'd0;
    errors   = 0;
  endfunction

  function void set_reg(logic idx, logic [ID_W-1:0] val);
    if (idx == CFG_BOS) bos_id = val;
    else rule_cnt = val[12:0];
  endfunction

  function void push_token(logic [ID_W-1:0] id, bit has, bit wcut);
    out_item_t t;
    t.token_id  = id;
    t.has_token = has;
    t.text_end  = 1'b0;
    t.word_cut  = wcut;
    tokens_due.push_back(t);
  endfunction

  function void close_word();
    int unsigned n, i, j;
    if (n_ids == 0) return;
    n = (rule_cnt > 4096) ? 4096 : rule_cnt;
    for (int unsigned r = 0; r < n; r++) begin
      i = 0;
      j = 0;
      while (i < n_ids) begin
        if (i + 1 < n_ids && word_ids[i] == pair_l[r] &&
            word_ids[i+1] == pair_r[r]) begin
          word_ids[j++] = pair_m[r];
          i += 2;
        end else begin
          word_ids[j++] = word_ids[i];
          i += 1;
        end
      end
      n_ids = j;
    end
    for (int unsigned k = 0; k < n_ids; k++) push_token(word_ids[k], 1'b1, cut);
    n_ids = 0;
    cut   = 0;
  endfunction

  function void note_input(in_item_t it);
    int start;
    if (it.func == FUNC_RULE) begin
      pair_l[it.rule_slot] = it.pair_left;
      pair_r[it.rule_slot] = it.pair_right;
      pair_m[it.rule_slot] = it.merged_token;
      return;
    end
    start = tokens_due.size();
    if (!in_text) begin
      push_token(bos_id, 1'b1, 1'b0);
      in_text = 1;
      n_ids   = 0;
      cut     = 0;
    end
    if (it.text_byte > SEP_LIMIT) begin
      if (n_ids < 32) word_ids[n_ids++] = {8'd0, it.text_byte};
      else cut = 1;
    end else begin
      close_word();
    end
    if (it.text_last) begin
      close_word();
      if (tokens_due.size() == start) push_token('0, 1'b0, 1'b0);
      tokens_due[tokens_due.size()-1].text_end = 1'b1;
      in_text = 0;
    end
  endfunction

  function void check(out_item_t got);
    out_item_t want;
    if (tokens_due.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected token: id %0d has %0b end %0b cut %0b",
                                 got.token_id, got.has_token, got.text_end, got.word_cut);
      return;
    end
    want = tokens_due.pop_front();
    if (got.token_id !== want.token_id || got.has_token !== want.has_token ||
        got.text_end !== want.text_end || got.word_cut !== want.word_cut) begin
      errors++;
      if (errors <= 10)
        $display({"token mismatch: expected id %0d has %0b end %0b cut %0b, ",
                  "got id %0d has %0b end %0b cut %0b"},
                 want.token_id, want.has_token, want.text_end, want.word_cut,
                 got.token_id, got.has_token, got.text_end, got.word_cut);
    end
  endfunction
endclass

module tb_bpe_word_encoder;
  localparam int IDLE_LIMIT = 400000;
  localparam int IN_W       = $bits(in_item_t);

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            push = 1'b0;
  logic            full;
  in_item_t        in_data = '0;
  logic            empty;
  logic            pop = 1'b0;
  out_item_t       out_data;
  logic            cfg_we = 1'b0;
  logic            cfg_index = CFG_BOS;
  logic [ID_W-1:0] cfg_data = '0;

  token_scoreboard sb = new();
  int              idle_cycles = 0;
  int              stall_mode = 0;
  int              stall_left = 0;
  bit              gaps_on = 1;
  int              items_sent = 0;

  bpe_word_encoder dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check(out_data);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 3) != 0);
      2: pop <= ($urandom_range(0, 3) == 0);
      default: pop <= ($urandom_range(0, 1) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_bpe_word_encoder: FAIL");
      $finish;
    end
  end

  function automatic in_item_t rule_item(int slot, logic [15:0] l, logic [15:0] r,
                                         logic [15:0] m);
    in_item_t it;
    it              = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.func         = FUNC_RULE;
    it.rule_slot    = SLOT_W'(slot);
    it.pair_left    = l;
    it.pair_right   = r;
    it.merged_token = m;
    return it;
  endfunction

  function automatic in_item_t byte_item(logic [7:0] b, bit last);
    in_item_t it;
    it           = in_item_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.func      = FUNC_BYTE;
    it.text_byte = b;
    it.text_last = last;
    return it;
  endfunction

  task automatic send(in_item_t it);
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    sb.note_input(it);
    items_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (sb.tokens_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [ID_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(byte_item(s[i], i == s.len() - 1));
  endtask

  function automatic logic [7:0] pick_byte();
    int c;
    c = $urandom_range(0, 9);
    if (c < 8) return 8'(97 + $urandom_range(0, 3));
    if (c == 8) return 8'($urandom_range(0, 32));
    return 8'($urandom_range(33, 255));
  endfunction

  initial begin
    int nrules;
    int tlen;
    logic [15:0] ids [$];

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: merges, chained merges, extremes, cut word, separators
    send(rule_item(0, 16'd97, 16'd98, 16'd300));
    send(rule_item(1, 16'd300, 16'd99, 16'hFFFF));
    send(rule_item(2, 16'hFFFF, 16'd0, 16'd0));
    write_reg(CFG_RULES, 16'd3);
    write_reg(CFG_BOS, 16'hFFFF);
    send(byte_item(8'd0, 1'b1));
    send(byte_item(8'd97, 1'b1));
    send_text("abc abab");
    send(byte_item(8'd255, 1'b0));
    send(byte_item(8'd33, 1'b0));
    send(rule_item(3, 16'd5, 16'd6, 16'd7));
    send(byte_item(8'd32, 1'b0));
    send(byte_item(8'd32, 1'b0));
    send(byte_item(8'd98, 1'b1));
    write_reg(CFG_BOS, 16'd0);
    for (int i = 0; i < 36; i++) send(byte_item(8'd122, 1'b0));
    send(byte_item(8'd10, 1'b1));
    write_reg(CFG_RULES, 16'd0);
    send_text("ab c");

    // random phases with small rule tables
    while (items_sent < 160) begin
      nrules  = $urandom_range(0, 8);
      gaps_on = ($urandom_range(0, 3) != 0);
      ids     = {16'd97, 16'd98, 16'd99, 16'd100};
      for (int r = 0; r < nrules; r++) begin
        logic [15:0] l, rr, m;
        l  = ids[$urandom_range(0, ids.size() - 1)];
        rr = ids[$urandom_range(0, ids.size() - 1)];
        m  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(400 + r);
        if ($urandom_range(0, 7) == 0) l = 16'($urandom);
        ids.push_back(m);
        send(rule_item(r, l, rr, m));
      end
      write_reg(CFG_RULES, 16'(nrules));
      write_reg(CFG_BOS, 16'($urandom));
      for (int t = 0; t < 3; t++) begin
        tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 12);
        for (int i = 0; i < tlen; i++) begin
          send(byte_item(tlen > 32 ? 8'(97 + $urandom_range(0, 1)) : pick_byte(),
                         i == tlen - 1));
          if (i == 2 && $urandom_range(0, 5) == 0)
            send(rule_item($urandom_range(nrules, 4095), 16'($urandom), 16'($urandom),
                           16'($urandom)));
        end
        if ($urandom_range(0, 4) == 0) drain();
      end
    end

    drain();
    if (sb.errors == 0 && sb.tokens_due.size() == 0)
      $display("tb_bpe_word_encoder: PASS");
    else
      $display("tb_bpe_word_encoder: FAIL");
    $finish;
  end
endmodule

// ----- bpe_word_encoder.f -----
rtl/bwe_pkg.sv
rtl/bwe_ram.sv
rtl/bwe_fifo.sv
rtl/bwe_front.sv
rtl/bwe_back.sv
rtl/bpe_word_encoder.sv
tb/sv/tb_bpe_word_encoder.sv
